>>> hw/rtl/scc_pkg.sv
package scc_pkg;

  localparam int CFG_W   = 11;
  localparam int NODE_IW = 11;
  localparam int CNT_OW  = 11;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR_ALL,
    CMD_CLR_VIS,
    CMD_EDGE_ACC,
    CMD_EDGE_WR,
    CMD_SOLVE_START,
    CMD_P1_RD,
    CMD_P1_NEXT,
    CMD_WALK_BEGIN,
    CMD_WALK_TOP,
    CMD_P2_START,
    CMD_P2_RD,
    CMD_P2_CHK,
    CMD_W_FIN,
    CMD_W_POP,
    CMD_W_RD,
    CMD_W_EDGE,
    CMD_W_PUSH_RD,
    CMD_W_PUSH,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic p_zero;
    logic sp_one;
    logic i_done;
    logic j_zero;
    logic visit_rd;
    logic t_ok;
    logic v_ok;
    logic clr_last;
    logic out_valid;
    logic rec;
  } stat_t;

endpackage

>>> hw/rtl/scc_if.sv
interface scc_in_if
  import scc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [NODE_IW-1:0] from_node;
  logic [NODE_IW-1:0] to_node;

  modport source (output valid, output op, output from_node, output to_node, input ready);
  modport sink (input valid, input op, input from_node, input to_node, output ready);
endinterface

interface scc_out_if
  import scc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CNT_OW-1:0] source_count;
  logic              edges_dropped;

  modport source (output valid, output source_count, output edges_dropped, input ready);
  modport sink (input valid, input source_count, input edges_dropped, output ready);
endinterface

>>> hw/rtl/scc_ctrl.sv
module scc_ctrl
  import scc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_op,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_EDGE, S_P1, S_P1C, S_WTOP, S_WL, S_WPOP, S_WE, S_WV,
    S_WP, S_RET, S_CLRV, S_P2S, S_P2, S_P2R, S_P2C, S_DONE, S_CLRA
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_RST_CLR: begin
        cmd = CMD_CLR_ALL;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (!in_op) begin
            cmd = CMD_EDGE_ACC;
            if (stat.edge_ok) state_nxt = S_EDGE;
          end else begin
            cmd       = CMD_SOLVE_START;
            state_nxt = S_P1;
          end
        end
      end
      S_EDGE: begin
        cmd       = CMD_EDGE_WR;
        state_nxt = S_IDLE;
      end
      S_P1: begin
        if (stat.i_done) begin
          state_nxt = S_CLRV;
        end else begin
          cmd       = CMD_P1_RD;
          state_nxt = S_P1C;
        end
      end
      S_P1C: begin
        if (stat.visit_rd) begin
          cmd       = CMD_P1_NEXT;
          state_nxt = S_P1;
        end else begin
          cmd       = CMD_WALK_BEGIN;
          state_nxt = S_WTOP;
        end
      end
      S_WTOP: begin
        cmd       = CMD_WALK_TOP;
        state_nxt = S_WL;
      end
      S_WL: begin
        if (stat.p_zero) begin
          cmd       = CMD_W_FIN;
          state_nxt = stat.sp_one ? S_RET : S_WPOP;
        end else begin
          cmd       = CMD_W_RD;
          state_nxt = S_WE;
        end
      end
      S_WPOP: begin
        cmd       = CMD_W_POP;
        state_nxt = S_WL;
      end
      S_WE: begin
        cmd       = CMD_W_EDGE;
        state_nxt = S_WV;
      end
      S_WV: begin
        if (stat.t_ok && !stat.visit_rd) begin
          cmd       = CMD_W_PUSH_RD;
          state_nxt = S_WP;
        end else begin
          state_nxt = S_WL;
        end
      end
      S_WP: begin
        cmd       = CMD_W_PUSH;
        state_nxt = S_WL;
      end
      S_RET: begin
        if (stat.rec) begin
          cmd       = CMD_P1_NEXT;
          state_nxt = S_P1;
        end else begin
          state_nxt = S_P2;
        end
      end
      S_CLRV: begin
        cmd = CMD_CLR_VIS;
        if (stat.clr_last) state_nxt = S_P2S;
      end
      S_P2S: begin
        cmd       = CMD_P2_START;
        state_nxt = S_P2;
      end
      S_P2: begin
        if (stat.j_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_P2_RD;
          state_nxt = S_P2R;
        end
      end
      S_P2R: begin
        cmd       = CMD_P2_CHK;
        state_nxt = S_P2C;
      end
      S_P2C: begin
        if (stat.v_ok && !stat.visit_rd) begin
          cmd       = CMD_WALK_BEGIN;
          state_nxt = S_WTOP;
        end else begin
          state_nxt = S_P2;
        end
      end
      S_DONE: begin
        if (!stat.out_valid) begin
          cmd       = CMD_RESULT;
          state_nxt = S_CLRA;
        end
      end
      S_CLRA: begin
        cmd = CMD_CLR_ALL;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_RST_CLR;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/scc_dp.sv
module scc_dp
  import scc_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [NODE_IW-1:0] in_from_node,
  input  logic [NODE_IW-1:0] in_to_node,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CNT_OW-1:0]  out_source_count,
  output logic               out_edges_dropped
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PW = $clog2(MAX_EDGES + 1);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = NW + PW;

  logic [PW-1:0] head_mem [MAX_NODES];
  logic [PW-1:0] next_mem [MAX_EDGES];
  logic [NW-1:0] tgt_mem  [MAX_EDGES];
  logic          vis_mem  [MAX_NODES];
  logic [NW-1:0] fo_mem   [MAX_NODES];
  logic [SW-1:0] stk_mem  [MAX_NODES];

  logic [CFG_W-1:0] node_count_r;
  logic [PW-1:0]    edge_total_r;
  logic             drop_r;
  logic [NW-1:0]    clr_r;
  logic [NW-1:0]    f_r, t_r, s_r, v_r, top_node_r;
  logic [PW-1:0]    top_edge_r;
  logic [CW-1:0]    i_r, j_r, fin_r, count_r, sp_r;
  logic             rec_r, t_ok_r, v_ok_r;
  logic             out_valid_r, out_drop_r;
  logic [CW-1:0]    out_count_r;

  logic [PW-1:0] head_rd_r, next_rd_r;
  logic [NW-1:0] tgt_rd_r, fo_rd_r;
  logic          vis_rd_r;
  logic [SW-1:0] stk_rd_r;

  logic [CW-1:0] n_eff;
  logic [31:0]   f_m1, t_m1, p_m1;
  logic          edge_ok;

  assign n_eff = (32'(node_count_r) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign f_m1  = 32'(in_from_node) - 32'd1;
  assign t_m1  = 32'(in_to_node) - 32'd1;
  assign p_m1  = 32'(top_edge_r) - 32'd1;

  assign edge_ok = (32'(edge_total_r) < 32'(MAX_EDGES)) && (in_from_node != '0) &&
                   (in_to_node != '0) && (32'(in_from_node) <= 32'(n_eff)) &&
                   (32'(in_to_node) <= 32'(n_eff));

  // head list memory
  logic          head_we;
  logic [NW-1:0] head_wa, head_ra;
  logic [PW-1:0] head_wd;

  always_comb begin
    head_we = 1'b0;
    head_wa = clr_r;
    head_wd = '0;
    head_ra = s_r;
    case (cmd)
      CMD_CLR_ALL: head_we = 1'b1;
      CMD_EDGE_WR: begin
        head_we = 1'b1;
        head_wa = f_r;
        head_wd = PW'(32'(edge_total_r) + 32'd1);
      end
      CMD_EDGE_ACC:   head_ra = f_m1[NW-1:0];
      CMD_WALK_BEGIN: head_ra = rec_r ? i_r[NW-1:0] : v_r;
      CMD_W_PUSH_RD:  head_ra = t_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  // edge memories
  always_ff @(posedge clk) begin
    if (cmd == CMD_EDGE_WR) begin
      next_mem[edge_total_r[EW-1:0]] <= head_rd_r;
      tgt_mem[edge_total_r[EW-1:0]]  <= t_r;
    end
    next_rd_r <= next_mem[p_m1[EW-1:0]];
    tgt_rd_r  <= tgt_mem[p_m1[EW-1:0]];
  end

  // visit marks
  logic          vis_we, vis_wd;
  logic [NW-1:0] vis_wa, vis_ra;

  always_comb begin
    vis_we = 1'b0;
    vis_wa = clr_r;
    vis_wd = 1'b0;
    vis_ra = i_r[NW-1:0];
    case (cmd)
      CMD_CLR_ALL, CMD_CLR_VIS: vis_we = 1'b1;
      CMD_WALK_BEGIN: begin
        vis_we = 1'b1;
        vis_wa = rec_r ? i_r[NW-1:0] : v_r;
        vis_wd = 1'b1;
      end
      CMD_W_PUSH_RD: begin
        vis_we = 1'b1;
        vis_wa = t_r;
        vis_wd = 1'b1;
      end
      CMD_P2_CHK: vis_ra = fo_rd_r;
      CMD_W_EDGE: vis_ra = tgt_rd_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_r <= vis_mem[vis_ra];
  end

  // finishing order and walk stack
  logic [CW-1:0] j_m1, sp_m1, sp_m2;
  assign j_m1  = j_r - CW'(1);
  assign sp_m1 = sp_r - CW'(1);
  assign sp_m2 = sp_r - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd == CMD_W_FIN && rec_r && (32'(fin_r) < 32'(MAX_NODES))) begin
      fo_mem[fin_r[NW-1:0]] <= top_node_r;
    end
    fo_rd_r <= fo_mem[j_m1[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_W_PUSH_RD) stk_mem[sp_m1[NW-1:0]] <= {top_node_r, top_edge_r};
    stk_rd_r <= stk_mem[sp_m2[NW-1:0]];
  end

  // control and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CFG_W'(1);
      edge_total_r <= '0;
      drop_r       <= 1'b0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      sp_r         <= '0;
      rec_r        <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd)
        CMD_CLR_ALL, CMD_CLR_VIS: begin
          clr_r <= (clr_r == NW'(MAX_NODES - 1)) ? '0 : clr_r + NW'(1);
        end
        CMD_EDGE_ACC: begin
          if (!edge_ok) drop_r <= 1'b1;
          f_r <= f_m1[NW-1:0];
          t_r <= t_m1[NW-1:0];
        end
        CMD_EDGE_WR: edge_total_r <= edge_total_r + PW'(1);
        CMD_SOLVE_START: begin
          i_r     <= '0;
          fin_r   <= '0;
          count_r <= '0;
          rec_r   <= 1'b1;
        end
        CMD_P1_NEXT: i_r <= i_r + CW'(1);
        CMD_WALK_BEGIN: begin
          s_r <= rec_r ? i_r[NW-1:0] : v_r;
          if (!rec_r) count_r <= count_r + CW'(1);
        end
        CMD_WALK_TOP: begin
          top_node_r <= s_r;
          top_edge_r <= head_rd_r;
          sp_r       <= CW'(1);
        end
        CMD_P2_START: begin
          j_r   <= fin_r;
          rec_r <= 1'b0;
        end
        CMD_P2_CHK: begin
          v_r    <= fo_rd_r;
          v_ok_r <= 32'(fo_rd_r) < 32'(n_eff);
          j_r    <= j_m1;
        end
        CMD_W_FIN: begin
          if (rec_r && (32'(fin_r) < 32'(MAX_NODES))) fin_r <= fin_r + CW'(1);
          sp_r <= sp_m1;
        end
        CMD_W_POP: begin
          top_node_r <= stk_rd_r[SW-1:PW];
          top_edge_r <= stk_rd_r[PW-1:0];
        end
        CMD_W_EDGE: begin
          top_edge_r <= next_rd_r;
          t_r        <= tgt_rd_r;
          t_ok_r     <= (32'(tgt_rd_r) < 32'(n_eff)) && (32'(sp_r) < 32'(MAX_NODES));
        end
        CMD_W_PUSH: begin
          top_node_r <= t_r;
          top_edge_r <= head_rd_r;
          sp_r       <= sp_r + CW'(1);
        end
        CMD_RESULT: begin
          out_valid_r  <= 1'b1;
          out_count_r  <= count_r;
          out_drop_r   <= drop_r;
          edge_total_r <= '0;
          drop_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat.edge_ok   = edge_ok;
  assign stat.p_zero    = (top_edge_r == '0) || (32'(top_edge_r) > 32'(MAX_EDGES));
  assign stat.sp_one    = (sp_r == CW'(1));
  assign stat.i_done    = (i_r >= n_eff);
  assign stat.j_zero    = (j_r == '0);
  assign stat.visit_rd  = vis_rd_r;
  assign stat.t_ok      = t_ok_r;
  assign stat.v_ok      = v_ok_r;
  assign stat.clr_last  = (clr_r == NW'(MAX_NODES - 1));
  assign stat.out_valid = out_valid_r;
  assign stat.rec       = rec_r;

  assign out_valid         = out_valid_r;
  assign out_source_count  = CNT_OW'(out_count_r);
  assign out_edges_dropped = out_drop_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= 32'(MAX_NODES)) else $error("walk stack depth out of range");
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_total_r) <= 32'(MAX_EDGES)) else $error("edge count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_W_FIN) |-> (sp_r != '0)) else $error("pop from empty walk stack");
  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RESULT) |-> !out_valid_r) else $error("result word overwritten");
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RESULT) |=> out_valid_r) else $error("result word not loaded");

endmodule

>>> hw/rtl/source_component_counter_top.sv
// edge word: a kept word is accepted in the idle state and written in the edge state; a dropped word is only accepted
// solve word: the result word follows pass one, the visit-mark clear between passes and pass two,
// which are made of per-node and per-edge walk steps
// throughput: one word at a time; the result register frees the input while it waits
// reset: synchronous active-low; then a pass over all MAX_NODES entries clears list heads and
// visit marks before the first word is taken; the same pass follows every solve
module source_component_counter_top
  import scc_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  scc_in_if.sink           in_ch,
  scc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  scc_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_from_node      (in_ch.from_node),
    .in_to_node        (in_ch.to_node),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_source_count  (out_ch.source_count),
    .out_edges_dropped (out_ch.edges_dropped)
  );

endmodule
